>>> hdl/stepper_microstep_positioner_unit_defines.svh
// Assertion macros shared by the stepper positioner RTL.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef STEPPER_MICROSTEP_POSITIONER_UNIT_DEFINES_SVH
`define STEPPER_MICROSTEP_POSITIONER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SMP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/smp_pkg.sv
// Shared types, constants and drive tables of the stepper microstep positioner.
// No dependencies; imported by every module of the block.
package smp_pkg;

   localparam int MicrostepsPerStep = 10;
   localparam int TableSize         = 4 * MicrostepsPerStep;
   localparam int PhaseWidth        = $clog2(TableSize);
   localparam int CsrAddrWidth      = 3;
   localparam int CsrDataWidth      = 32;

   localparam longint PiHalfQ30 = 64'sd1686629713;
   localparam longint OneQ30    = 64'sd1073741824;

   // angle of one microstep in Q30, split into quotient and remainder
   localparam longint AngleStepQ30 = PiHalfQ30 / MicrostepsPerStep;
   localparam longint AngleStepRem = PiHalfQ30 % MicrostepsPerStep;

   localparam logic [15:0] IntervalReset = 16'd5000;

   // Register indexes
   localparam logic RegStepInterval = 1'b0;

   typedef struct packed {
      logic                         coils_on;
      logic [PhaseWidth-1:0]        phase;
      logic [15:0]                  tick_count;
      logic signed [31:0]           target;
      logic signed [31:0]           position;
   } smp_state_type;

   typedef struct packed {
      logic [3:0]         coil_drive;
      logic [7:0]         pwm_a;
      logic [7:0]         pwm_b;
      logic signed [31:0] position;
      logic               ready_res;
   } smp_result_type;

   localparam smp_state_type StateReset = '0;

   typedef logic [TableSize-1:0][7:0] duty_table_type;
   typedef logic [TableSize-1:0][3:0] coil_table_type;

   // sin of r/M quarter turns in Q2.30, Taylor series through x^17
   function automatic longint sine_q30(input int r);
      longint x;
      longint frac;
      longint x2;
      longint term;
      longint sum;
      if (r <= 0) begin
         return 64'sd0;
      end
      if (r >= MicrostepsPerStep) begin
         return OneQ30;
      end
      x    = AngleStepQ30 * longint'(r);
      frac = AngleStepRem * longint'(r);
      // fold the leftover remainder into the angle
      while (frac >= MicrostepsPerStep) begin
         frac = frac - MicrostepsPerStep;
         x    = x + 1;
      end
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >>> 30) / 6;   sum = sum - term;
      term = ((term * x2) >>> 30) / 20;  sum = sum + term;
      term = ((term * x2) >>> 30) / 42;  sum = sum - term;
      term = ((term * x2) >>> 30) / 72;  sum = sum + term;
      term = ((term * x2) >>> 30) / 110; sum = sum - term;
      term = ((term * x2) >>> 30) / 156; sum = sum + term;
      term = ((term * x2) >>> 30) / 210; sum = sum - term;
      term = ((term * x2) >>> 30) / 272; sum = sum + term;
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > OneQ30) begin
         sum = OneQ30;
      end
      return sum;
   endfunction

   // largest v with v*v*2^30 <= 65025*s
   function automatic logic [7:0] root_duty(input longint s);
      longint lim;
      int     v;
      lim = 64'sd65025 * s;
      v   = 0;
      for (int k = 1; k <= 255; k++) begin
         if (longint'(k) * longint'(k) * OneQ30 <= lim) begin
            v = k;
         end
      end
      return 8'(v);
   endfunction

   function automatic duty_table_type build_duty_a();
      duty_table_type t;
      int r;
      for (int i = 0; i < TableSize; i++) begin
         r = (i >= 2 * MicrostepsPerStep) ? i - 2 * MicrostepsPerStep : i;
         if (r > MicrostepsPerStep) begin
            r = 2 * MicrostepsPerStep - r;
         end
         t[i] = root_duty(sine_q30(r));
      end
      return t;
   endfunction

   localparam duty_table_type DutyATable = build_duty_a();

   function automatic duty_table_type build_duty_b();
      duty_table_type t;
      int src;
      for (int i = 0; i < TableSize; i++) begin
         src  = (i >= MicrostepsPerStep) ? i - MicrostepsPerStep
                                         : i + TableSize - MicrostepsPerStep;
         t[i] = DutyATable[src];
      end
      return t;
   endfunction

   function automatic coil_table_type build_coils();
      coil_table_type t;
      int shifted;
      for (int i = 0; i < TableSize; i++) begin
         shifted = (i >= MicrostepsPerStep) ? i - MicrostepsPerStep
                                            : i + TableSize - MicrostepsPerStep;
         t[i][0] = (i < 2 * MicrostepsPerStep);
         t[i][1] = !(i < 2 * MicrostepsPerStep);
         t[i][2] = (shifted < 2 * MicrostepsPerStep);
         t[i][3] = !(shifted < 2 * MicrostepsPerStep);
      end
      return t;
   endfunction

   localparam duty_table_type DutyBTable = build_duty_b();
   localparam coil_table_type CoilTable  = build_coils();

endpackage

>>> hdl/smp_state_store.sv
// Single-entry synchronous state memory with a registered read.
// Forwards the last written record so an update can follow in the next cycle.
// Depends on smp_pkg.
`include "stepper_microstep_positioner_unit_defines.svh"

module smp_state_store (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  smp_pkg::smp_state_type wr_data,
   output smp_pkg::smp_state_type rd_data
);
   import smp_pkg::*;

   smp_state_type mem [1];
   smp_state_type rdata_ff;
   smp_state_type byp_data_ff;
   logic          byp_valid_ff;
   logic          mem_we;
   smp_state_type mem_wd;

   assign mem_we = reset || wr_en;
   assign mem_wd = reset ? StateReset : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[0] <= mem_wd;
      end
      rdata_ff <= mem[0];
   end

   // hold the freshest record until the memory read catches up
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_valid_ff <= 1'b1;
      end else begin
         byp_valid_ff <= wr_en;
      end
      byp_data_ff <= mem_wd;
   end

   assign rd_data = byp_valid_ff ? byp_data_ff : rdata_ff;

   `SMP_ASSERT_NEXT(a_fwd_write, mem_we, rd_data == $past(mem_wd), "write not forwarded")
   `SMP_ASSERT_NOW(a_mem_read, $past(mem_we, 2) && !$past(mem_we),
      rd_data == $past(mem_wd, 2), "memory read lost a write")

endmodule

>>> hdl/smp_update.sv
// Next-state and result logic of the positioner: target move, tick divider,
// microstep toward the target and drive table lookup. Depends on smp_pkg.
module smp_update (
   input  smp_pkg::smp_state_type  cur,
   input  logic                    command,
   input  logic signed [31:0]      move_amount,
   input  logic [15:0]             step_interval,
   output smp_pkg::smp_state_type  nxt,
   output smp_pkg::smp_result_type result
);
   import smp_pkg::*;

   logic signed [32:0] sum;
   logic [16:0]        tick_next;
   logic               at_target;
   logic               go_down;

   assign sum       = {cur.target[31], cur.target} + {move_amount[31], move_amount};
   assign tick_next = {1'b0, cur.tick_count} + 17'd1;
   assign at_target = (cur.position == cur.target);
   assign go_down   = (cur.target < cur.position);

   always_comb begin
      nxt = cur;
      if (command) begin
         if (sum[32] != sum[31]) begin
            nxt.target = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         end else begin
            nxt.target = sum[31:0];
         end
      end else if (at_target) begin
         nxt.tick_count = 16'd0;
      end else if (tick_next >= {1'b0, step_interval}) begin
         nxt.tick_count = 16'd0;
         nxt.coils_on   = 1'b1;
         // advance position and table phase together, phase wraps
         if (go_down) begin
            nxt.position = cur.position - 32'sd1;
            nxt.phase    = (cur.phase == '0) ? PhaseWidth'(TableSize - 1)
                                             : cur.phase - PhaseWidth'(1);
         end else begin
            nxt.position = cur.position + 32'sd1;
            nxt.phase    = (cur.phase == PhaseWidth'(TableSize - 1)) ? '0
                                             : cur.phase + PhaseWidth'(1);
         end
      end else begin
         nxt.tick_count = tick_next[15:0];
      end
   end

   always_comb begin
      result.position  = nxt.position;
      result.ready_res = (nxt.position == nxt.target);
      if (nxt.coils_on) begin
         result.coil_drive = CoilTable[nxt.phase];
         result.pwm_a      = DutyATable[nxt.phase];
         result.pwm_b      = DutyBTable[nxt.phase];
      end else begin
         result.coil_drive = 4'd0;
         result.pwm_a      = 8'd0;
         result.pwm_b      = 8'd0;
      end
   end

endmodule

>>> hdl/stepper_microstep_positioner_unit.sv
// Stepper microstep positioner. Takes one item per clock: a move (command 1) adds
// move_amount to the saturating target, a tick (command 0) advances the step divider
// and moves the position one microstep toward the target every step_interval ticks.
// Each item is processed against a single-entry state memory whose last write is
// forwarded, and its result is presented in the output register on the next cycle;
// a result that waits blocks a new transfer only while it is not taken.
// step_interval sits at CSR byte address 0 (reset 5000; 0 behaves as 1).
// Depends on smp_pkg, smp_state_store, smp_update.
`include "stepper_microstep_positioner_unit_defines.svh"

module stepper_microstep_positioner_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic signed [31:0]                req_move_amount,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [3:0]                        rsp_coil_drive,
   output logic [7:0]                        rsp_pwm_a,
   output logic [7:0]                        rsp_pwm_b,
   output logic signed [31:0]                rsp_position,
   output logic                              rsp_ready_res,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [smp_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [smp_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [smp_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import smp_pkg::*;

   logic           accept;
   logic           csr_wr;
   logic [15:0]    interval_ff;
   logic [15:0]    interval_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   smp_result_type rsp_data_ff;
   smp_state_type  cur_state;
   smp_state_type  nxt_state;
   smp_result_type result;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   smp_state_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (nxt_state),
      .rd_data (cur_state)
   );

   smp_update u_update (
      .cur           (cur_state),
      .command       (req_command),
      .move_amount   (req_move_amount),
      .step_interval (interval_ff),
      .nxt           (nxt_state),
      .result        (result)
   );

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      interval_in = interval_ff;
      if (csr_wr && csr_paddr[2] == RegStepInterval) begin
         interval_in = csr_pwdata[15:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == RegStepInterval) begin
         csr_prdata = {{(CsrDataWidth - 16){1'b0}}, interval_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= IntervalReset;
      end else begin
         interval_ff <= interval_in;
      end
   end

   // output register: load on transfer in, drop on transfer out
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_coil_drive = rsp_data_ff.coil_drive;
   assign rsp_pwm_a      = rsp_data_ff.pwm_a;
   assign rsp_pwm_b      = rsp_data_ff.pwm_b;
   assign rsp_position   = rsp_data_ff.position;
   assign rsp_ready_res  = rsp_data_ff.ready_res;

   `SMP_ASSERT_NEXT(a_accept_rsp, accept, rsp_valid_ff, "accepted item gave no result")
   `SMP_ASSERT_NEXT(a_rsp_state, accept,
      rsp_position == cur_state.position &&
      rsp_ready_res == (cur_state.position == cur_state.target),
      "result disagrees with stored state")

endmodule
